// File: rtl/fzsg_pkg.sv
package fzsg_pkg;

	localparam int SPEED_BITS = 16;
	localparam int CNT_BITS = 16;
	localparam int NUM_GROUPS_DEF = 8;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [3:0] {
		FN_TICK        = 4'd0,
		FN_SET_SPEED   = 4'd1,
		FN_FULL_SPEED  = 4'd2,
		FN_SET_FLOOR   = 4'd3,
		FN_INCREASE    = 4'd4,
		FN_DECREASE    = 4'd5,
		FN_ACTIVE_ALLOW = 4'd6,
		FN_FLOOR_ALLOW = 4'd7,
		FN_DEC_ALLOW   = 4'd8
	} func_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_FULL_SPEED    = 3'd0,
		CFG_CEILING_SPEED = 3'd1,
		CFG_SPEED_BASE    = 3'd2,
		CFG_INC_DELAY     = 3'd3,
		CFG_DEC_INTERVAL  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0]            func;
		logic [SPEED_BITS-1:0] value;
		logic [2:0]            group_index;
		logic                  allow;
	} evt_t;

	typedef struct packed {
		logic [SPEED_BITS-1:0] target_speed;
		logic                  speed_written;
		logic                  zone_active;
		logic [SPEED_BITS-1:0] floor_speed;
		logic                  increase_held;
	} res_t;

	typedef struct packed {
		logic [SPEED_BITS-1:0] full_speed;
		logic [SPEED_BITS-1:0] ceiling_speed;
		logic [SPEED_BITS-1:0] speed_base;
		logic [CNT_BITS-1:0]   inc_delay;
		logic [CNT_BITS-1:0]   dec_interval;
	} cfg_t;

	// Permission view handed from the group masks to the speed logic
	typedef struct packed {
		logic active;
		logic active_nxt;
		logic floor_ok;
		logic dec_ok;
	} perm_t;

endpackage

// File: rtl/fan_zone_speed_governor_core.sv
// Fan zone speed governor. Each request on evt is one event (tick, speed set,
// full speed, floor update, increase, decrease, or a group allow bit) and
// produces exactly one result on res carrying the target speed, whether the
// fans were written, the zone active flag, the floor and the increase hold
// flag. A request is registered, evaluated against the zone state in the next
// cycle and its result registered, and one request is taken every cycle as
// long as res is drained; the single update stage with its output register
// sets that rate. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must do so only while idle, as the core does not enforce it.
module fan_zone_speed_governor_core #(
	parameter int NUM_GROUPS = fzsg_pkg::NUM_GROUPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                evt_valid,
	output logic                                evt_ready,
	input  fzsg_pkg::evt_t                      evt,
	output logic                                res_valid,
	input  logic                                res_ready,
	output fzsg_pkg::res_t                      res,
	input  logic                                cfg_we,
	input  logic [fzsg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [fzsg_pkg::SPEED_BITS-1:0]     cfg_data
);

	logic            valid_s1;
	fzsg_pkg::evt_t  evt_s1;
	logic            res_valid_q;
	fzsg_pkg::res_t  res_q;
	fzsg_pkg::cfg_t  cfg_q;
	fzsg_pkg::perm_t perm;
	fzsg_pkg::res_t  res_d;
	logic            adv;

	assign adv = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (evt_valid && evt_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1 <= evt;
		end
		if (adv) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_speed <= '0;
			cfg_q.ceiling_speed <= '1;
			cfg_q.speed_base <= '0;
			cfg_q.inc_delay <= fzsg_pkg::CNT_BITS'(5);
			cfg_q.dec_interval <= fzsg_pkg::CNT_BITS'(30);
		end else if (cfg_we) begin
			case (cfg_index)
				fzsg_pkg::CFG_FULL_SPEED:    cfg_q.full_speed <= cfg_data;
				fzsg_pkg::CFG_CEILING_SPEED: cfg_q.ceiling_speed <= cfg_data;
				fzsg_pkg::CFG_SPEED_BASE:    cfg_q.speed_base <= cfg_data;
				fzsg_pkg::CFG_INC_DELAY:     cfg_q.inc_delay <= cfg_data;
				fzsg_pkg::CFG_DEC_INTERVAL:  cfg_q.dec_interval <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fzsg_perm #(
		.NUM_GROUPS(NUM_GROUPS)
	) u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv),
		.item   (evt_s1),
		.perm   (perm)
	);

	fzsg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv),
		.item   (evt_s1),
		.cfg    (cfg_q),
		.perm   (perm),
		.res    (res_d)
	);

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// File: rtl/fzsg_perm.sv
module fzsg_perm #(
	parameter int NUM_GROUPS = fzsg_pkg::NUM_GROUPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  fzsg_pkg::evt_t   item,
	output fzsg_pkg::perm_t  perm
);

	logic [NUM_GROUPS-1:0] active_known_q, active_bits_q;
	logic [NUM_GROUPS-1:0] floor_known_q, floor_bits_q;
	logic [NUM_GROUPS-1:0] dec_known_q, dec_bits_q;
	logic                  active_q;

	logic [NUM_GROUPS-1:0] grp_bit;
	logic                  in_range;
	logic [NUM_GROUPS-1:0] act_known_d, act_bits_d;
	logic                  act_flag_d;

	always_comb begin
		for (int i = 0; i < NUM_GROUPS; i++) begin
			grp_bit[i] = (32'(item.group_index) == i);
		end
	end

	assign in_range = |grp_bit;
	assign act_known_d = active_known_q | grp_bit;
	assign act_bits_d = item.allow ? (active_bits_q | grp_bit) : (active_bits_q & ~grp_bit);
	assign act_flag_d = item.allow && ((act_bits_d & act_known_d) == act_known_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_known_q <= '0;
			active_bits_q <= '0;
			floor_known_q <= '0;
			floor_bits_q <= '0;
			dec_known_q <= '0;
			dec_bits_q <= '0;
			active_q <= 1'b1;
		end else if (commit && in_range) begin
			case (item.func)
				fzsg_pkg::FN_ACTIVE_ALLOW: begin
					active_known_q <= act_known_d;
					active_bits_q <= act_bits_d;
					active_q <= act_flag_d;
				end
				fzsg_pkg::FN_FLOOR_ALLOW: begin
					floor_known_q <= floor_known_q | grp_bit;
					floor_bits_q <= item.allow ? (floor_bits_q | grp_bit)
						: (floor_bits_q & ~grp_bit);
				end
				fzsg_pkg::FN_DEC_ALLOW: begin
					dec_known_q <= dec_known_q | grp_bit;
					dec_bits_q <= item.allow ? (dec_bits_q | grp_bit)
						: (dec_bits_q & ~grp_bit);
				end
				default: begin
				end
			endcase
		end
	end

	assign perm.active = active_q;
	// active flag as it stands once the request in the stage is applied
	assign perm.active_nxt = (item.func == fzsg_pkg::FN_ACTIVE_ALLOW && in_range)
		? act_flag_d : active_q;
	assign perm.floor_ok = (floor_bits_q & floor_known_q) == floor_known_q;
	assign perm.dec_ok = (dec_bits_q & dec_known_q) == dec_known_q;

endmodule

// File: rtl/fzsg_core.sv
module fzsg_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  fzsg_pkg::evt_t   item,
	input  fzsg_pkg::cfg_t   cfg,
	input  fzsg_pkg::perm_t  perm,
	output fzsg_pkg::res_t   res
);

	localparam int SW = fzsg_pkg::SPEED_BITS;
	localparam int CW = fzsg_pkg::CNT_BITS;

	logic [SW-1:0] target_q, floor_q, inc_delta_q, dec_delta_q;
	logic [CW-1:0] inc_count_q, dec_count_q;
	logic          inc_running_q;

	logic [SW-1:0] target_d, floor_d, inc_delta_d, dec_delta_d;
	logic [CW-1:0] inc_count_d, dec_count_d;
	logic          inc_running_d;
	logic          wrote;

	logic [SW-1:0] base;
	logic [SW-1:0] inc_req_delta;
	logic          inc_en;
	logic [SW:0]   inc_sum;
	logic [SW-1:0] inc_speed;
	logic [SW-1:0] dec_base, dec_sub, dec_speed;
	logic [CW-1:0] inc_cnt_nxt, dec_cnt_nxt;

	assign base = (cfg.speed_base != '0) ? cfg.speed_base : target_q;

	// Increase path: a raise request, or a floor that lifts above the target
	assign inc_req_delta = (item.func == fzsg_pkg::FN_INCREASE) ? item.value
		: (item.value - target_q);
	assign inc_en = (inc_req_delta > inc_delta_q) && (target_q < cfg.ceiling_speed);
	assign inc_sum = {1'b0, base} + {1'b0, inc_req_delta - inc_delta_q};
	assign inc_speed = (inc_sum > {1'b0, cfg.ceiling_speed}) ? cfg.ceiling_speed
		: inc_sum[SW-1:0];

	// Decrease path: clamp to ceiling, step down, stop at the floor
	assign dec_base = (base > cfg.ceiling_speed) ? cfg.ceiling_speed : base;
	assign dec_sub = dec_base - dec_delta_q;
	assign dec_speed = ((dec_base < dec_delta_q) || (dec_sub < floor_q)) ? floor_q : dec_sub;

	assign inc_cnt_nxt = (inc_count_q != '1) ? inc_count_q + 1'b1 : inc_count_q;
	assign dec_cnt_nxt = (dec_count_q != '1) ? dec_count_q + 1'b1 : dec_count_q;

	always_comb begin
		target_d = target_q;
		floor_d = floor_q;
		inc_delta_d = inc_delta_q;
		dec_delta_d = dec_delta_q;
		inc_count_d = inc_count_q;
		dec_count_d = dec_count_q;
		inc_running_d = inc_running_q;
		wrote = 1'b0;
		case (item.func)
			fzsg_pkg::FN_TICK: begin
				if (inc_running_q) begin
					if (inc_cnt_nxt >= cfg.inc_delay) begin
						inc_running_d = 1'b0;
						inc_count_d = '0;
						inc_delta_d = '0;
					end else begin
						inc_count_d = inc_cnt_nxt;
					end
				end
				if (cfg.dec_interval == '0) begin
					dec_count_d = '0;
				end else if (dec_cnt_nxt >= cfg.dec_interval) begin
					dec_count_d = '0;
					dec_delta_d = '0;
					// evaluate against the hold state left by this same tick
					if (perm.dec_ok && inc_delta_d == '0 && !inc_running_d && perm.active) begin
						target_d = dec_speed;
						wrote = 1'b1;
					end
				end else begin
					dec_count_d = dec_cnt_nxt;
				end
			end
			fzsg_pkg::FN_SET_SPEED: begin
				if (perm.active) begin
					target_d = item.value;
					wrote = 1'b1;
				end
			end
			fzsg_pkg::FN_FULL_SPEED: begin
				if (cfg.full_speed != '0) begin
					target_d = cfg.full_speed;
					wrote = 1'b1;
				end
			end
			fzsg_pkg::FN_SET_FLOOR, fzsg_pkg::FN_INCREASE: begin
				if (item.func == fzsg_pkg::FN_INCREASE || perm.floor_ok) begin
					if (item.func == fzsg_pkg::FN_SET_FLOOR) begin
						floor_d = item.value;
					end
					if (inc_en && (item.func == fzsg_pkg::FN_INCREASE
						|| target_q < item.value)) begin
						inc_delta_d = inc_req_delta;
						inc_running_d = 1'b1;
						inc_count_d = '0;
						if (perm.active) begin
							target_d = inc_speed;
							wrote = 1'b1;
						end
					end
				end
			end
			fzsg_pkg::FN_DECREASE: begin
				if (dec_delta_q == '0 || item.value < dec_delta_q) begin
					dec_delta_d = item.value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			floor_q <= '0;
			inc_delta_q <= '0;
			dec_delta_q <= '0;
			inc_count_q <= '0;
			dec_count_q <= '0;
			inc_running_q <= 1'b0;
		end else if (commit) begin
			target_q <= target_d;
			floor_q <= floor_d;
			inc_delta_q <= inc_delta_d;
			dec_delta_q <= dec_delta_d;
			inc_count_q <= inc_count_d;
			dec_count_q <= dec_count_d;
			inc_running_q <= inc_running_d;
		end
	end

	assign res.target_speed = target_d;
	assign res.speed_written = wrote;
	assign res.floor_speed = floor_d;
	assign res.increase_held = inc_running_d;
	assign res.zone_active = perm.active_nxt;

endmodule
